// ===== sv/keypad_scan_number_entry_defines.svh =====
// Assertion macros for the keypad scanner.
`ifndef KEYPAD_SCAN_NUMBER_ENTRY_DEFINES_SVH
`define KEYPAD_SCAN_NUMBER_ENTRY_DEFINES_SVH

// Property that holds on every cycle out of reset.
`define KPSE_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define KPSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/kpse_pkg.sv =====
// Types, constants and key table for the keypad scanner.
package kpse_pkg;

  localparam int SETTLE_WIDTH_DEF = 16;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 32;

  localparam logic [CFG_ADDR_W-1:0] ADDR_SETTLE_TICKS = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_ENTRY_ENABLE = 3'd4;
  localparam int ADDR_SEL_BIT = 2;

  localparam logic [15:0] SETTLE_TICKS_RST = 16'd100;
  localparam logic        ENTRY_ENABLE_RST = 1'b1;

  localparam logic [3:0] COLS_NONE = 4'hF;
  localparam logic [3:0] ROWS_ALL  = 4'h0;

  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  localparam logic [7:0] KEY_ZERO  = "0";
  localparam logic [7:0] KEY_NINE  = "9";
  localparam logic [7:0] KEY_BKSP  = "_";
  localparam logic [7:0] KEY_ENTER = "C";

  localparam logic [7:0] KEY_MAP [4][4] = '{
    '{"1", "2", "3", "A"},
    '{"4", "5", "6", "_"},
    '{"7", "8", "9", "C"},
    '{"*", "0", "#", "D"}
  };

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ROWS    = 3'd1,
    PH_COLS    = 3'd2,
    PH_RELEASE = 3'd3,
    PH_SETTLE  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [3:0]  row_drive;
    logic        key_valid;
    logic [7:0]  key_code;
    logic        number_valid;
    logic [31:0] number_value;
  } result_t;

  function automatic logic [3:0] one_row_low(input logic [1:0] r);
    return ~(4'b0001 << r);
  endfunction

endpackage

// ===== sv/kpse_in_if.sv =====
// Input channel: sampled column levels.
interface kpse_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] col_levels;

  modport source (output valid, output col_levels, input ready);
  modport sink   (input valid, input col_levels, output ready);
endinterface

// ===== sv/kpse_out_if.sv =====
// Result channel: row drive, decoded key and completed number.
interface kpse_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  row_drive;
  logic        key_valid;
  logic [7:0]  key_code;
  logic        number_valid;
  logic [31:0] number_value;

  modport source (output valid, output row_drive, output key_valid, output key_code,
                  output number_valid, output number_value, input ready);
  modport sink   (input valid, input row_drive, input key_valid, input key_code,
                  input number_valid, input number_value, output ready);
endinterface

// ===== sv/keypad_scan_number_entry.sv =====
// Top level: 4x4 keypad scanner with decimal number entry.
//
//   channel  | direction | payload
//   in_ch    | in        | col_levels
//   out_ch   | out       | row_drive, key_valid, key_code, number_valid, number_value
//   cfg APB  | in/out    | settle_ticks (0x0), entry_enable (0x4)
//
// One transfer per cycle while in_ch is not stalled; each result is registered before out_ch offers it.
// Scan state updates at the input transfer; the result lands in an output
// register backed by a one-entry skid register, so input stalls only when both are full.
// Synchronous active-low reset; no clearing pass.
`include "keypad_scan_number_entry_defines.svh"

module keypad_scan_number_entry #(
  parameter int SETTLE_WIDTH = kpse_pkg::SETTLE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  kpse_in_if.sink                         in_ch,
  kpse_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kpse_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [kpse_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [kpse_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int CW = (SETTLE_WIDTH > 16) ? SETTLE_WIDTH : 16;

  logic [15:0]              settle_ticks_r;
  logic                     entry_enable_r;
  kpse_pkg::phase_t         phase_r, phase_nxt;
  logic [1:0]               row_index_r, row_index_nxt;
  logic [SETTLE_WIDTH-1:0]  settle_count_r, settle_count_nxt;
  logic [31:0]              acc_r, acc_nxt;
  kpse_pkg::result_t        out_r, skid_r, res;
  logic                     out_valid_r, skid_valid_r;

  logic                     in_fire, out_pop, cfg_wr, any_low;
  logic [1:0]               col_idx;
  logic [7:0]               key_code;
  logic [CW-1:0]            ticks_ext, settle_max;
  logic [SETTLE_WIDTH-1:0]  settle_load, settle_dec;
  logic [63:0]              div_prod;
  logic [31:0]              acc_div10, acc_mul10;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[kpse_pkg::ADDR_SEL_BIT] ? {31'b0, entry_enable_r}
                                                 : {16'b0, settle_ticks_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ticks_r <= kpse_pkg::SETTLE_TICKS_RST;
      entry_enable_r <= kpse_pkg::ENTRY_ENABLE_RST;
    end else if (cfg_wr) begin
      if (paddr[kpse_pkg::ADDR_SEL_BIT]) begin
        entry_enable_r <= pwdata[0];
      end else begin
        settle_ticks_r <= pwdata[15:0];
      end
    end
  end

  // handshake
  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_pop     = out_valid_r && out_ch.ready;

  // shared datapath terms
  assign any_low = in_ch.col_levels != kpse_pkg::COLS_NONE;

  always_comb begin
    priority if (!in_ch.col_levels[0]) col_idx = 2'd0;
    else if (!in_ch.col_levels[1])     col_idx = 2'd1;
    else if (!in_ch.col_levels[2])     col_idx = 2'd2;
    else                               col_idx = 2'd3;
  end

  assign key_code = kpse_pkg::KEY_MAP[row_index_r][col_idx];

  assign ticks_ext   = CW'(settle_ticks_r);
  assign settle_max  = CW'({SETTLE_WIDTH{1'b1}});
  assign settle_load = (ticks_ext > settle_max) ? settle_max[SETTLE_WIDTH-1:0]
                                                : ticks_ext[SETTLE_WIDTH-1:0];
  assign settle_dec  = (settle_count_r != '0) ? settle_count_r - SETTLE_WIDTH'(1)
                                              : settle_count_r;

  assign div_prod  = 64'(acc_r) * 64'(kpse_pkg::RECIP10);
  assign acc_div10 = 32'(div_prod[63:kpse_pkg::DIV10_SHIFT]);
  assign acc_mul10 = {acc_r[28:0], 3'b000} + {acc_r[30:0], 1'b0}
                   + 32'(key_code - kpse_pkg::KEY_ZERO);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      kpse_pkg::PH_ROWS: begin
        if (any_low) begin
          phase_nxt = kpse_pkg::PH_COLS;
        end else if (row_index_r == 2'd3) begin
          phase_nxt = kpse_pkg::PH_IDLE;
        end
      end
      kpse_pkg::PH_COLS: begin
        phase_nxt = any_low ? kpse_pkg::PH_RELEASE : kpse_pkg::PH_IDLE;
      end
      kpse_pkg::PH_RELEASE: begin
        if (!any_low) begin
          phase_nxt = (settle_load == '0) ? kpse_pkg::PH_IDLE : kpse_pkg::PH_SETTLE;
        end
      end
      kpse_pkg::PH_SETTLE: begin
        if (settle_dec == '0) phase_nxt = kpse_pkg::PH_IDLE;
      end
      default: begin
        phase_nxt = any_low ? kpse_pkg::PH_ROWS : kpse_pkg::PH_IDLE;
      end
    endcase
  end

  // outputs and datapath state
  always_comb begin
    row_index_nxt    = row_index_r;
    settle_count_nxt = settle_count_r;
    acc_nxt          = acc_r;
    res              = '0;
    res.row_drive    = kpse_pkg::ROWS_ALL;
    unique case (phase_r)
      kpse_pkg::PH_ROWS: begin
        if (!any_low && row_index_r != 2'd3) begin
          row_index_nxt = row_index_r + 2'd1;
          res.row_drive = kpse_pkg::one_row_low(row_index_r + 2'd1);
        end
      end
      kpse_pkg::PH_COLS: begin
        if (any_low) begin
          res.key_valid = 1'b1;
          res.key_code  = key_code;
          if (entry_enable_r) begin
            if (key_code >= kpse_pkg::KEY_ZERO && key_code <= kpse_pkg::KEY_NINE) begin
              acc_nxt = acc_mul10;
            end else if (key_code == kpse_pkg::KEY_BKSP) begin
              acc_nxt = acc_div10;
            end else if (key_code == kpse_pkg::KEY_ENTER) begin
              res.number_valid = 1'b1;
              res.number_value = acc_r;
              acc_nxt          = '0;
            end
          end
        end
      end
      kpse_pkg::PH_RELEASE: begin
        if (!any_low && settle_load != '0) settle_count_nxt = settle_load;
      end
      kpse_pkg::PH_SETTLE: begin
        settle_count_nxt = settle_dec;
      end
      default: begin
        if (any_low) begin
          row_index_nxt = 2'd0;
          res.row_drive = kpse_pkg::one_row_low(2'd0);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= kpse_pkg::PH_IDLE;
      row_index_r    <= 2'd0;
      settle_count_r <= '0;
      acc_r          <= '0;
    end else if (in_fire) begin
      phase_r        <= phase_nxt;
      row_index_r    <= row_index_nxt;
      settle_count_r <= settle_count_nxt;
      acc_r          <= acc_nxt;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_pop) begin
        out_valid_r  <= skid_valid_r || in_fire;
        skid_valid_r <= 1'b0;
      end else if (in_fire) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_pop) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (in_fire) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.row_drive    = out_r.row_drive;
  assign out_ch.key_valid    = out_r.key_valid;
  assign out_ch.key_code     = out_r.key_code;
  assign out_ch.number_valid = out_r.number_valid;
  assign out_ch.number_value = out_r.number_value;

  `KPSE_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_r || out_valid_r, "skid full with output empty")
  `KPSE_ASSERT_ALWAYS(a_number_on_enter, !(out_valid_r && out_r.number_valid) || (out_r.key_valid && out_r.key_code == kpse_pkg::KEY_ENTER), "number without enter key")
  `KPSE_ASSERT_NEXT(a_key_to_release, in_fire && phase_r == kpse_pkg::PH_COLS && any_low, phase_r == kpse_pkg::PH_RELEASE, "decoded key did not enter release wait")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for keypad_scan_number_entry: simulated keypad stimulus, tick-by-tick scoreboard.
module tb;

  localparam int LONG_HOLD    = 200;
  localparam int RANDOM_TICKS = 700;

  logic                            clk     = 1'b0;
  logic                            rst_n   = 1'b0;
  logic                            psel    = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite  = 1'b0;
  logic [kpse_pkg::CFG_ADDR_W-1:0] paddr   = '0;
  logic [kpse_pkg::CFG_DATA_W-1:0] pwdata  = '0;
  logic [kpse_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  kpse_in_if  in_ch ();
  kpse_out_if out_ch ();

  keypad_scan_number_entry u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scanner state as the testbench sees it
  kpse_pkg::phase_t scan_phase  = kpse_pkg::PH_IDLE;
  logic [1:0]       scan_row    = '0;
  logic [15:0]      settle_left = '0;
  logic [31:0]      number_acc  = '0;
  logic [15:0]      cfg_settle  = kpse_pkg::SETTLE_TICKS_RST;
  logic             cfg_entry   = kpse_pkg::ENTRY_ENABLE_RST;
  logic [3:0]       rows_now    = kpse_pkg::ROWS_ALL;

  kpse_pkg::result_t pending_reports [$];
  int      err_count  = 0;
  int      tick_count = 0;
  bit      gaps_on    = 1'b1;
  bit      hold_req   = 1'b0;

  function automatic kpse_pkg::result_t scan_tick(input logic [3:0] cols);
    kpse_pkg::result_t res;
    int      c;
    logic    any_low;
    res     = '0;
    any_low = (cols != kpse_pkg::COLS_NONE);
    unique case (scan_phase)
      kpse_pkg::PH_ROWS: begin
        if (any_low) begin
          scan_phase = kpse_pkg::PH_COLS;
        end else if (scan_row == 2'd3) begin
          scan_phase = kpse_pkg::PH_IDLE;
        end else begin
          scan_row      = scan_row + 2'd1;
          res.row_drive = 4'hF ^ (4'b0001 << scan_row);
        end
      end
      kpse_pkg::PH_COLS: begin
        c = 0;
        while (c < 4 && cols[c]) c++;
        if (c == 4) begin
          scan_phase = kpse_pkg::PH_IDLE;
        end else begin
          res.key_valid = 1'b1;
          res.key_code  = kpse_pkg::KEY_MAP[scan_row][c];
          if (cfg_entry) begin
            if (res.key_code >= kpse_pkg::KEY_ZERO && res.key_code <= kpse_pkg::KEY_NINE) begin
              number_acc = number_acc * 32'd10 + 32'(res.key_code - kpse_pkg::KEY_ZERO);
            end else if (res.key_code == kpse_pkg::KEY_BKSP) begin
              number_acc = number_acc / 32'd10;
            end else if (res.key_code == kpse_pkg::KEY_ENTER) begin
              res.number_valid = 1'b1;
              res.number_value = number_acc;
              number_acc       = '0;
            end
          end
          scan_phase = kpse_pkg::PH_RELEASE;
        end
      end
      kpse_pkg::PH_RELEASE: begin
        if (!any_low) begin
          if (cfg_settle == '0) begin
            scan_phase = kpse_pkg::PH_IDLE;
          end else begin
            settle_left = cfg_settle;
            scan_phase  = kpse_pkg::PH_SETTLE;
          end
        end
      end
      kpse_pkg::PH_SETTLE: begin
        if (settle_left != '0) settle_left--;
        if (settle_left == '0) scan_phase = kpse_pkg::PH_IDLE;
      end
      default: begin
        scan_phase = kpse_pkg::PH_IDLE;
        if (any_low) begin
          scan_row      = '0;
          scan_phase    = kpse_pkg::PH_ROWS;
          res.row_drive = 4'hE;
        end
      end
    endcase
    rows_now = res.row_drive;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic int key_slot(input logic [7:0] code);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        if (kpse_pkg::KEY_MAP[r][c] == code) return r * 4 + c;
    return 0;
  endfunction

  // column levels seen by the pins for a set of held keys under a row drive
  function automatic logic [3:0] col_sense(input logic [15:0] keys, input logic [3:0] rows);
    logic [3:0] cols;
    cols = kpse_pkg::COLS_NONE;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        if (keys[r * 4 + c] && !rows[r]) cols[c] = 1'b0;
    return cols;
  endfunction

  function automatic logic [15:0] pick_keys();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 16'(1) << key_slot(kpse_pkg::KEY_ENTER);
    if (r < 22) return 16'(1) << key_slot(kpse_pkg::KEY_BKSP);
    if (r < 85) return 16'(1) << key_slot(kpse_pkg::KEY_ZERO + 8'($urandom_range(0, 9)));
    if (r < 95) return 16'(1) << $urandom_range(0, 15);
    return 16'($urandom_range(1, 65535));
  endfunction

  task automatic drive_tick(input logic [3:0] cols);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.col_levels <= cols;
    do @(posedge clk); while (!in_ch.ready);
    pending_reports.push_back(scan_tick(cols));
    tick_count++;
  endtask

  task automatic press_keys(input logic [15:0] keys, input int hold);
    repeat (hold) drive_tick(col_sense(keys, rows_now));
  endtask

  task automatic release_keys(input int extra);
    while (scan_phase != kpse_pkg::PH_IDLE) drive_tick(kpse_pkg::COLS_NONE);
    repeat (extra) drive_tick(kpse_pkg::COLS_NONE);
  endtask

  task automatic press_char(input logic [7:0] code);
    press_keys(16'(1) << key_slot(code), 7);
    release_keys($urandom_range(0, 2));
  endtask

  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [kpse_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == kpse_pkg::ADDR_SETTLE_TICKS) cfg_settle = data[15:0];
    else if (addr == kpse_pkg::ADDR_ENTRY_ENABLE) cfg_entry = data[0];
  endtask

  // reset values: settle of 100, entry on
  task automatic test_defaults();
    press_char("4");
    press_char(kpse_pkg::KEY_ENTER);
    wait_quiet();
  endtask

  task automatic test_special_keys();
    write_reg(kpse_pkg::ADDR_SETTLE_TICKS, 32'd0);
    press_char("A");
    press_char("D");
    press_char("*");
    press_char("#");
    // glitch gone before any row is found
    press_keys(16'(1) << key_slot("5"), 1);
    release_keys(0);
    // row found, key gone before the column read
    press_keys(16'(1) << key_slot("2"), 2);
    release_keys(0);
    press_char("7");
    press_char("3");
    press_char(kpse_pkg::KEY_BKSP);
    press_char("8");
    press_char(kpse_pkg::KEY_ENTER);
    press_char(kpse_pkg::KEY_ENTER);
    press_keys((16'(1) << key_slot("1")) | (16'(1) << key_slot("9")), 7);
    release_keys(1);
    press_char(kpse_pkg::KEY_ENTER);
    wait_quiet();
  endtask

  task automatic test_entry_off();
    press_char("4");
    wait_quiet();
    write_reg(kpse_pkg::ADDR_ENTRY_ENABLE, 32'd0);
    press_char("6");
    press_char(kpse_pkg::KEY_BKSP);
    press_char(kpse_pkg::KEY_ENTER);
    wait_quiet();
    write_reg(kpse_pkg::ADDR_ENTRY_ENABLE, 32'd1);
    press_char(kpse_pkg::KEY_ENTER);
    wait_quiet();
  endtask

  task automatic test_overflow();
    write_reg(kpse_pkg::ADDR_SETTLE_TICKS, 32'd1);
    repeat (12) press_char("9");
    press_char(kpse_pkg::KEY_ENTER);
    wait_quiet();
  endtask

  task automatic test_settle_no_gaps();
    write_reg(kpse_pkg::ADDR_SETTLE_TICKS, 32'd24);
    gaps_on = 1'b0;
    press_char("5");
    gaps_on = 1'b1;
    wait_quiet();
    write_reg(kpse_pkg::ADDR_SETTLE_TICKS, 32'd3);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    press_char("3");
    press_char(kpse_pkg::KEY_ENTER);
    wait_quiet();
  endtask

  task automatic test_random();
    int         stop_at;
    int         sel;
    int         r;
    logic [3:0] noise;
    stop_at = tick_count + RANDOM_TICKS;
    while (tick_count < stop_at) begin
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        wait_quiet();
        r = $urandom_range(0, 99);
        if (r < 15) write_reg(kpse_pkg::ADDR_SETTLE_TICKS, 32'd0);
        else if (r < 80) write_reg(kpse_pkg::ADDR_SETTLE_TICKS, 32'($urandom_range(1, 6)));
        else write_reg(kpse_pkg::ADDR_SETTLE_TICKS, 32'($urandom_range(7, 40)));
        write_reg(kpse_pkg::ADDR_ENTRY_ENABLE, ($urandom_range(0, 4) != 0) ? 32'd1 : 32'd0);
      end else if (sel < 14) begin
        repeat ($urandom_range(1, 8)) begin
          noise = 4'($urandom_range(0, 15));
          drive_tick(noise);
        end
      end else if (sel < 18) begin
        gaps_on = ~gaps_on;
      end else begin
        r = ($urandom_range(0, 9) < 2) ? $urandom_range(1, 5) : $urandom_range(6, 12);
        press_keys(pick_keys(), r);
        release_keys($urandom_range(0, 3));
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin : sink_ready
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (gaps_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_result
    kpse_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $error("result transfer with nothing expected");
        err_count++;
      end else begin
        want = pending_reports.pop_front();
        if (out_ch.row_drive !== want.row_drive) begin
          $error("row_drive: expected %h, got %h", want.row_drive, out_ch.row_drive);
          err_count++;
        end
        if (out_ch.key_valid !== want.key_valid) begin
          $error("key_valid: expected %b, got %b", want.key_valid, out_ch.key_valid);
          err_count++;
        end
        if (out_ch.key_code !== want.key_code) begin
          $error("key_code: expected %h, got %h", want.key_code, out_ch.key_code);
          err_count++;
        end
        if (out_ch.number_valid !== want.number_valid) begin
          $error("number_valid: expected %b, got %b", want.number_valid, out_ch.number_valid);
          err_count++;
        end
        if (out_ch.number_value !== want.number_value) begin
          $error("number_value: expected %0d, got %0d", want.number_value, out_ch.number_value);
          err_count++;
        end
      end
    end
  end

  initial begin : run
    int waited;
    in_ch.valid      = 1'b0;
    in_ch.col_levels = kpse_pkg::COLS_NONE;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_special_keys();
    test_entry_off();
    test_overflow();
    test_settle_no_gaps();
    test_backpressure();
    test_random();
    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_reports.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d expected results never arrived", pending_reports.size());
      err_count += pending_reports.size();
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
